// ===== sv/trapped_insn_emulation_decode_assert.svh =====
// assertion macros shared by the trapped instruction emulation decode modules
// no dependencies; included by the modules that carry concurrent checks
`ifndef TRAPPED_INSN_EMULATION_DECODE_ASSERT_SVH
`define TRAPPED_INSN_EMULATION_DECODE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TIED_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TIED_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tied_pkg.sv =====
// shared types and constants for the trapped instruction emulation decode
// no dependencies; used by every module of the block
package tied_pkg;

	// architectural register width of the hart being emulated
	localparam int XLEN = 64;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_COUNTER_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_PRESENT     = 1'd1;
	localparam logic [31:0] USER_COUNTER_ENABLE_RST = 32'h0000_0000;
	localparam logic [31:0] COUNTER_PRESENT_RST     = 32'h0000_0007;

	// instruction encoding
	localparam logic [6:0]  OPC_SYSTEM    = 7'h73;
	localparam logic [6:0]  OPC_AMO       = 7'h2f;
	localparam logic [11:0] CSR_LOW_BASE  = 12'hc00;
	localparam logic [11:0] CSR_HIGH_BASE = 12'hc80;
	localparam logic [2:0]  F3_WORD       = 3'd2;
	localparam logic [2:0]  F3_DOUBLE     = 3'd3;

	// depth of the queue between decode and execute
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ACT_REDIRECT = 2'd0,
		ACT_COUNTER  = 2'd1,
		ACT_AMO      = 2'd2
	} action_t;

	// funct5 codes of the supported amos
	typedef enum logic [4:0] {
		AMO_ADD  = 5'h00,
		AMO_SWAP = 5'h01,
		AMO_XOR  = 5'h04,
		AMO_OR   = 5'h08,
		AMO_AND  = 5'h0c,
		AMO_MIN  = 5'h10,
		AMO_MAX  = 5'h14,
		AMO_MINU = 5'h18,
		AMO_MAXU = 5'h1c
	} amo_op_t;

	typedef struct packed {
		logic [31:0] instruction;
		logic        from_user;
		logic [63:0] old_value;
		logic [63:0] source_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  counter_index;
		logic        high_half;
		logic [4:0]  dest_reg;
		logic [4:0]  address_reg;
		logic        double_width;
		logic [63:0] store_value;
		logic [63:0] rd_value;
	} out_item_t;

	// classified item handed from decode to execute
	typedef struct packed {
		action_t     action;
		logic [4:0]  counter_index;
		logic        high_half;
		logic [4:0]  dest_reg;
		logic [4:0]  address_reg;
		logic        double_width;
		amo_op_t     op;
		logic [63:0] opa;
		logic [63:0] opb;
	} cmd_t;

endpackage

// ===== sv/trapped_insn_emulation_decode.sv =====
// Trapped instruction emulation decode. Each item is one trapped 32-bit
// instruction with its origin privilege, the loaded memory value and rs2; each
// item gives exactly one result: redirect, a counter CSR read to emulate
// (counter number, high half, rd), or an AMO to emulate (rd, rs1, width, the
// value to store and the old value for rd). Items are accepted through push/full
// and results leave through empty/pop, one per cycle sustained while pop stays
// high. Decode writes a two-entry queue at the accepting edge, and the execute
// stage (a 64-bit add and compares) writes the result register from the queue
// head once the result stage is free. full rises only after the result side
// has stalled long enough to fill the queue. The configuration port takes a
// write in any cycle.
// depends on tied_pkg, tied_front, tied_queue and tied_back
module trapped_insn_emulation_decode #(
	parameter int XLEN = tied_pkg::XLEN
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tied_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tied_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	output logic                             full,
	input  tied_pkg::in_item_t               item,
	output logic                             empty,
	input  logic                             pop,
	output tied_pkg::out_item_t              result
);

	tied_pkg::cmd_t dec_cmd;
	tied_pkg::cmd_t q_cmd;
	logic           q_full;
	logic           q_empty;
	logic           q_take;

	// decode and classify
	tied_front #(
		.XLEN (XLEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (dec_cmd)
	);

	// decoupling queue
	tied_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !q_full),
		.wr_data (dec_cmd),
		.full    (q_full),
		.rd_en   (q_take),
		.rd_data (q_cmd),
		.empty   (q_empty)
	);

	// execute and hold result
	tied_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (q_cmd),
		.cmd_take  (q_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	assign full = q_full;

endmodule

// ===== sv/tied_front.sv =====
// decode side: configuration registers and classification of trapped instructions
// depends on tied_pkg
module tied_front #(
	parameter int XLEN = tied_pkg::XLEN
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tied_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tied_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  tied_pkg::in_item_t               item,
	output tied_pkg::cmd_t                   cmd
);

	logic [31:0] user_counter_enable_q;
	logic [31:0] counter_present_q;

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [11:0] csr;
	logic [4:0]  f5;
	logic [4:0]  cnt_n;
	logic        csr_low;
	logic        csr_high;
	logic        csr_form_ok;
	logic        cnt_ok;
	logic        amo_code_ok;
	logic        amo_width_ok;
	logic        amo_dbl;
	tied_pkg::amo_op_t op_dec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_counter_enable_q <= tied_pkg::USER_COUNTER_ENABLE_RST;
			counter_present_q     <= tied_pkg::COUNTER_PRESENT_RST;
		end else if (cfg_we) begin
			if (cfg_index == tied_pkg::CFG_USER_COUNTER_ENABLE) begin
				user_counter_enable_q <= cfg_data[31:0];
			end
			if (cfg_index == tied_pkg::CFG_COUNTER_PRESENT) begin
				counter_present_q <= cfg_data[31:0];
			end
		end
	end

	// instruction fields
	assign opc = item.instruction[6:0];
	assign rd  = item.instruction[11:7];
	assign f3  = item.instruction[14:12];
	assign rs1 = item.instruction[19:15];
	assign csr = item.instruction[31:20];
	assign f5  = item.instruction[31:27];

	// counter csr read: csrrs/csrrc and immediate forms with rs1 zero
	assign cnt_n       = csr[4:0];
	assign csr_form_ok = f3[1] && (rs1 == 5'd0);
	assign csr_low     = (csr[11:5] == tied_pkg::CSR_LOW_BASE[11:5]);
	assign csr_high    = (XLEN == 32) && (csr[11:5] == tied_pkg::CSR_HIGH_BASE[11:5]);
	assign cnt_ok      = csr_form_ok && (csr_low || csr_high)
		&& (!item.from_user || user_counter_enable_q[cnt_n])
		&& counter_present_q[cnt_n];

	// amo opcode and width checks
	always_comb begin
		amo_code_ok = 1'b1;
		op_dec      = tied_pkg::AMO_ADD;
		unique case (f5)
			tied_pkg::AMO_ADD:  op_dec = tied_pkg::AMO_ADD;
			tied_pkg::AMO_SWAP: op_dec = tied_pkg::AMO_SWAP;
			tied_pkg::AMO_XOR:  op_dec = tied_pkg::AMO_XOR;
			tied_pkg::AMO_OR:   op_dec = tied_pkg::AMO_OR;
			tied_pkg::AMO_AND:  op_dec = tied_pkg::AMO_AND;
			tied_pkg::AMO_MIN:  op_dec = tied_pkg::AMO_MIN;
			tied_pkg::AMO_MAX:  op_dec = tied_pkg::AMO_MAX;
			tied_pkg::AMO_MINU: op_dec = tied_pkg::AMO_MINU;
			tied_pkg::AMO_MAXU: op_dec = tied_pkg::AMO_MAXU;
			default:            amo_code_ok = 1'b0;
		endcase
	end

	assign amo_dbl      = (f3 == tied_pkg::F3_DOUBLE) && (XLEN == 64);
	assign amo_width_ok = (f3 == tied_pkg::F3_WORD) || amo_dbl;

	// classify; fields that do not apply stay zero
	always_comb begin
		cmd = '0;
		cmd.action = tied_pkg::ACT_REDIRECT;
		cmd.op     = tied_pkg::AMO_ADD;
		priority if (opc == tied_pkg::OPC_SYSTEM && cnt_ok) begin
			cmd.action        = tied_pkg::ACT_COUNTER;
			cmd.counter_index = cnt_n;
			cmd.high_half     = csr_high;
			cmd.dest_reg      = rd;
		end else if (opc == tied_pkg::OPC_AMO && amo_code_ok && amo_width_ok) begin
			cmd.action       = tied_pkg::ACT_AMO;
			cmd.dest_reg     = rd;
			cmd.address_reg  = rs1;
			cmd.double_width = amo_dbl;
			cmd.op           = op_dec;
			cmd.opa = amo_dbl ? item.old_value
				: {{32{item.old_value[31]}}, item.old_value[31:0]};
			cmd.opb = amo_dbl ? item.source_value
				: {{32{item.source_value[31]}}, item.source_value[31:0]};
		end else begin
			cmd.action = tied_pkg::ACT_REDIRECT;
		end
	end

endmodule

// ===== sv/tied_queue.sv =====
// two-entry queue of classified items between decode and execute
// depends on tied_pkg and trapped_insn_emulation_decode_assert.svh
`include "trapped_insn_emulation_decode_assert.svh"

module tied_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tied_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output tied_pkg::cmd_t rd_data,
	output logic           empty
);

	localparam int DEPTH = tied_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

	tied_pkg::cmd_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`TIED_ASSERT_IMP(a_queue_no_overflow, clk, arst_n, wr_en, !full || rd_en, "queue written while full")
	`TIED_ASSERT_IMP(a_queue_no_underflow, clk, arst_n, rd_en, !empty, "queue read while empty")
	`TIED_ASSERT_NXT(a_queue_count_up, clk, arst_n, wr_en && !rd_en, count_q == $past(count_q) + 1'b1, "count did not grow on write")

endmodule

// ===== sv/tied_back.sv =====
// execute side: amo arithmetic and the registered result stage
// depends on tied_pkg and trapped_insn_emulation_decode_assert.svh
`include "trapped_insn_emulation_decode_assert.svh"

module tied_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  tied_pkg::cmd_t      cmd,
	output logic                cmd_take,
	output tied_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop
);

	logic                result_valid_q;
	tied_pkg::out_item_t result_q;
	tied_pkg::out_item_t next_result;
	logic [63:0]         sum;
	logic                slt;
	logic                ult;
	logic [63:0]         amo_res;
	logic                advance;

	// result stage frees when empty or being taken this cycle
	assign advance  = !result_valid_q || (pop && result_valid_q);
	assign cmd_take = cmd_valid && advance;

	// one add and two compares, signed and unsigned, per item
	assign sum = cmd.opa + cmd.opb;
	assign slt = $signed(cmd.opa) < $signed(cmd.opb);
	assign ult = cmd.opa < cmd.opb;

	always_comb begin
		unique case (cmd.op)
			tied_pkg::AMO_ADD:  amo_res = sum;
			tied_pkg::AMO_SWAP: amo_res = cmd.opb;
			tied_pkg::AMO_XOR:  amo_res = cmd.opa ^ cmd.opb;
			tied_pkg::AMO_OR:   amo_res = cmd.opa | cmd.opb;
			tied_pkg::AMO_AND:  amo_res = cmd.opa & cmd.opb;
			tied_pkg::AMO_MIN:  amo_res = slt ? cmd.opa : cmd.opb;
			tied_pkg::AMO_MAX:  amo_res = slt ? cmd.opb : cmd.opa;
			tied_pkg::AMO_MINU: amo_res = ult ? cmd.opa : cmd.opb;
			tied_pkg::AMO_MAXU: amo_res = ult ? cmd.opb : cmd.opa;
			default:            amo_res = '0;
		endcase
	end

	// assemble the result item
	always_comb begin
		next_result               = '0;
		next_result.action        = cmd.action;
		next_result.counter_index = cmd.counter_index;
		next_result.high_half     = cmd.high_half;
		next_result.dest_reg      = cmd.dest_reg;
		next_result.address_reg   = cmd.address_reg;
		next_result.double_width  = cmd.double_width;
		if (cmd.action == tied_pkg::ACT_AMO) begin
			next_result.store_value = cmd.double_width ? amo_res : {32'h0, amo_res[31:0]};
			next_result.rd_value    = cmd.opa;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			result_q <= next_result;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= cmd_valid;
		end
	end

	assign result = result_q;
	assign empty  = !result_valid_q;

	`TIED_ASSERT_IMP(a_word_store_upper_zero, clk, arst_n, result_valid_q && result_q.action == tied_pkg::ACT_AMO && !result_q.double_width, result_q.store_value[63:32] == 32'h0, "word amo store has upper bits set")
	`TIED_ASSERT_IMP(a_counter_no_data, clk, arst_n, result_valid_q && result_q.action == tied_pkg::ACT_COUNTER, result_q.store_value == '0 && result_q.rd_value == '0 && result_q.address_reg == '0, "counter read carries amo data")
	`TIED_ASSERT_IMP(a_redirect_all_zero, clk, arst_n, result_valid_q && result_q.action == tied_pkg::ACT_REDIRECT, result_q == '0, "redirect result not all zero")

endmodule

// ===== test/trapped_insn_emulation_decode_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for trapped_insn_emulation_decode: directed and random trapped items
// depends on tied_pkg and the block itself; predicts each decode and checks it field by field
module trapped_insn_emulation_decode_tb;

	// system funct3 codes for the csr forms, and the byte width code for amos
	localparam logic [2:0] F3_CSRRW  = 3'd1;
	localparam logic [2:0] F3_CSRRS  = 3'd2;
	localparam logic [2:0] F3_CSRRC  = 3'd3;
	localparam logic [2:0] F3_CSRRSI = 3'd6;
	localparam logic [2:0] F3_CSRRCI = 3'd7;
	localparam logic [2:0] F3_BYTE   = 3'd0;
	// amo funct5 codes that are not emulated
	localparam logic [4:0] F5_LR = 5'h02;
	localparam logic [4:0] F5_SC = 5'h03;
	// counter csr bases
	localparam logic [11:0] CSR_LO = tied_pkg::CSR_LOW_BASE;
	localparam logic [11:0] CSR_HI = tied_pkg::CSR_HIGH_BASE;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 115;
	localparam int NUM_PHASES  = 6;
	localparam int NUM_OPS     = 9;

	localparam tied_pkg::amo_op_t AMO_OPS [NUM_OPS] = '{tied_pkg::AMO_ADD,
		tied_pkg::AMO_SWAP, tied_pkg::AMO_XOR, tied_pkg::AMO_OR, tied_pkg::AMO_AND,
		tied_pkg::AMO_MIN, tied_pkg::AMO_MAX, tied_pkg::AMO_MINU, tied_pkg::AMO_MAXU};

	// predicts the decode of each accepted trap and checks the block's results in order
	class trap_decode_checker;
		logic [31:0]         user_enable;
		logic [31:0]         present;
		tied_pkg::out_item_t expected_decodes[$];
		int                  mismatches;
		int                  checked;
		int                  redirects;
		int                  counter_reads;
		int                  amos;

		function new();
			user_enable = tied_pkg::USER_COUNTER_ENABLE_RST;
			present     = tied_pkg::COUNTER_PRESENT_RST;
		endfunction

		function tied_pkg::out_item_t decode_trap(tied_pkg::in_item_t it);
			tied_pkg::out_item_t r;
			logic [31:0] insn;
			logic [4:0]  rd, rs1, n;
			logic [2:0]  f3;
			logic [11:0] csr;
			logic        dbl, slt, ult, known;
			logic [63:0] a, b, res;
			r = '0;
			insn = it.instruction;
			rd = insn[11:7];
			f3 = insn[14:12];
			rs1 = insn[19:15];
			csr = insn[31:20];
			n = csr[4:0];
			// compressed or zero word goes to the supervisor
			if (insn[1:0] != 2'b11)
				return r;
			// counter csr reads
			if (insn[6:0] == tied_pkg::OPC_SYSTEM) begin
				if (!(f3 == F3_CSRRS || f3 == F3_CSRRC || f3 == F3_CSRRSI || f3 == F3_CSRRCI)
						|| rs1 != 5'd0)
					return r;
				if (csr[11:5] == CSR_LO[11:5]) begin
					r.high_half = 1'b0;
				end else if (tied_pkg::XLEN == 32 && csr[11:5] == CSR_HI[11:5]) begin
					r.high_half = 1'b1;
				end else begin
					return '0;
				end
				if (it.from_user && !user_enable[n])
					return '0;
				if (!present[n])
					return '0;
				r.action = tied_pkg::ACT_COUNTER;
				r.counter_index = n;
				r.dest_reg = rd;
				return r;
			end
			if (insn[6:0] != tied_pkg::OPC_AMO)
				return r;
			// amo: supported op and width only
			known = 1'b0;
			for (int k = 0; k < NUM_OPS; k++)
				if (insn[31:27] == AMO_OPS[k])
					known = 1'b1;
			if (!known)
				return r;
			if (f3 == tied_pkg::F3_WORD)
				dbl = 1'b0;
			else if (f3 == tied_pkg::F3_DOUBLE && tied_pkg::XLEN == 64)
				dbl = 1'b1;
			else
				return r;
			a = dbl ? it.old_value : {{32{it.old_value[31]}}, it.old_value[31:0]};
			b = dbl ? it.source_value : {{32{it.source_value[31]}}, it.source_value[31:0]};
			slt = $signed(a) < $signed(b);
			ult = a < b;
			case (tied_pkg::amo_op_t'(insn[31:27]))
				tied_pkg::AMO_SWAP: res = b;
				tied_pkg::AMO_ADD:  res = a + b;
				tied_pkg::AMO_XOR:  res = a ^ b;
				tied_pkg::AMO_AND:  res = a & b;
				tied_pkg::AMO_OR:   res = a | b;
				tied_pkg::AMO_MIN:  res = slt ? a : b;
				tied_pkg::AMO_MAX:  res = slt ? b : a;
				tied_pkg::AMO_MINU: res = ult ? a : b;
				default:            res = ult ? b : a;
			endcase
			if (!dbl)
				res[63:32] = '0;
			r.action = tied_pkg::ACT_AMO;
			r.dest_reg = rd;
			r.address_reg = rs1;
			r.double_width = dbl;
			r.store_value = res;
			r.rd_value = a;
			return r;
		endfunction

		function void note_trap(tied_pkg::in_item_t it);
			tied_pkg::out_item_t exp;
			exp = decode_trap(it);
			expected_decodes.push_back(exp);
			if (exp.action == tied_pkg::ACT_COUNTER)
				counter_reads++;
			else if (exp.action == tied_pkg::ACT_AMO)
				amos++;
			else
				redirects++;
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_decode(tied_pkg::out_item_t got);
			tied_pkg::out_item_t exp;
			if (expected_decodes.size() == 0) begin
				$error("result with no item pending: %h", got);
				mismatches++;
				return;
			end
			exp = expected_decodes.pop_front();
			checked++;
			compare_field("action", 64'(exp.action), 64'(got.action));
			compare_field("counter_index", 64'(exp.counter_index), 64'(got.counter_index));
			compare_field("high_half", 64'(exp.high_half), 64'(got.high_half));
			compare_field("dest_reg", 64'(exp.dest_reg), 64'(got.dest_reg));
			compare_field("address_reg", 64'(exp.address_reg), 64'(got.address_reg));
			compare_field("double_width", 64'(exp.double_width), 64'(got.double_width));
			compare_field("store_value", exp.store_value, got.store_value);
			compare_field("rd_value", exp.rd_value, got.rd_value);
		endfunction

		function int pending();
			return expected_decodes.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tied_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tied_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            push = 1'b0;
	logic                            full;
	tied_pkg::in_item_t              trap_item = '0;
	logic                            empty;
	logic                            pop = 1'b0;
	tied_pkg::out_item_t             result;

	int                    send_idle_pct = 0;
	int                    take_idle_pct = 0;
	logic                  hold_go = 1'b0;
	int                    hold_left = 0;
	int                    stall_count = 0;
	int                    settings = 0;
	trap_decode_checker    decodes = new();

	trapped_insn_emulation_decode i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (trap_item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side: check accepted results, random pop, long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				decodes.check_decode(result);
			if (hold_go)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= take_idle_pct);
			end
		end
	end

	// watchdog on cycles without any accepted item or result
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [31:0] amo_insn(logic [4:0] f5, logic [2:0] f3, logic [4:0] rd,
			logic [4:0] rs1, logic [4:0] rs2, logic [1:0] aqrl);
		return {f5, aqrl, rs2, rs1, f3, rd, tied_pkg::OPC_AMO};
	endfunction

	function automatic logic [31:0] csr_insn(logic [11:0] csr, logic [2:0] f3, logic [4:0] rd,
			logic [4:0] rs1);
		return {csr, rs1, f3, rd, tied_pkg::OPC_SYSTEM};
	endfunction

	function automatic tied_pkg::in_item_t trap(logic [31:0] insn, logic user,
			logic [63:0] oldv, logic [63:0] srcv);
		tied_pkg::in_item_t it;
		it.instruction = insn;
		it.from_user = user;
		it.old_value = oldv;
		it.source_value = srcv;
		return it;
	endfunction

	// operands biased toward sign and carry boundaries at both widths
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return {$urandom, 32'h8000_0000};
			5: return {$urandom, 32'h7fff_ffff};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly well-formed amos and counter reads, the rest broken forms and noise
	function automatic tied_pkg::in_item_t random_trap();
		logic [31:0] insn;
		logic [11:0] csr;
		logic [2:0]  f3;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			f3 = $urandom_range(0, 1) ? tied_pkg::F3_DOUBLE : tied_pkg::F3_WORD;
			insn = amo_insn(AMO_OPS[$urandom_range(0, NUM_OPS - 1)], f3, 5'($urandom),
				5'($urandom), 5'($urandom), 2'($urandom));
		end else if (pick < 80) begin
			case ($urandom_range(0, 3))
				0: f3 = F3_CSRRS;
				1: f3 = F3_CSRRC;
				2: f3 = F3_CSRRSI;
				default: f3 = F3_CSRRCI;
			endcase
			csr = ($urandom_range(0, 7) == 0) ? CSR_HI : CSR_LO;
			csr[4:0] = 5'($urandom);
			insn = csr_insn(csr, f3, 5'($urandom), 5'd0);
		end else if (pick < 90) begin
			insn = amo_insn(5'($urandom), 3'($urandom), 5'($urandom), 5'($urandom),
				5'($urandom), 2'($urandom));
		end else if (pick < 96) begin
			insn = csr_insn(12'($urandom), 3'($urandom), 5'($urandom), 5'($urandom));
		end else begin
			insn = $urandom;
		end
		return trap(insn, 1'($urandom), pick_operand(), pick_operand());
	endfunction

	task automatic send_trap(input tied_pkg::in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		trap_item <= it;
		do
			@(posedge clk);
		while (full);
		decodes.note_trap(it);
	endtask

	// both registers, one after the other; only while the block is idle
	task automatic set_counters(input logic [31:0] enable_mask, input logic [31:0] present_mask);
		cfg_we <= 1'b1;
		cfg_index <= tied_pkg::CFG_USER_COUNTER_ENABLE;
		cfg_data <= enable_mask;
		@(posedge clk);
		cfg_index <= tied_pkg::CFG_COUNTER_PRESENT;
		cfg_data <= present_mask;
		@(posedge clk);
		cfg_we <= 1'b0;
		decodes.user_enable = enable_mask;
		decodes.present = present_mask;
		settings++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (decodes.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// directed items under the reset register values, then with every counter enabled
	task automatic run_directed();
		logic [63:0] wold, wsrc;
		wold = 64'hdead_beef_ffff_ffff;
		wsrc = 64'h1234_5678_0000_0001;
		// zero and compressed words
		send_trap(trap(32'h0, 1'b0, '1, '1));
		send_trap(trap(32'hffff_fffd, 1'b1, '1, '0));
		// counter reads and the ways they are refused
		send_trap(trap(csr_insn(CSR_LO, F3_CSRRS, 5'd5, 5'd0), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO + 12'd1, F3_CSRRC, 5'd31, 5'd0), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO + 12'd2, F3_CSRRSI, 5'd0, 5'd0), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO + 12'd3, F3_CSRRCI, 5'd7, 5'd0), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO, F3_CSRRS, 5'd1, 5'd0), 1'b1, '0, '0));
		send_trap(trap(csr_insn(CSR_HI, F3_CSRRS, 5'd2, 5'd0), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO, F3_CSRRW, 5'd3, 5'd0), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO, F3_CSRRS, 5'd4, 5'd7), 1'b0, '0, '0));
		send_trap(trap(csr_insn(CSR_LO + 12'd31, F3_CSRRS, 5'd6, 5'd0), 1'b0, '0, '0));
		// every word amo, signed and unsigned orders disagree on these operands
		for (int k = 0; k < NUM_OPS; k++)
			send_trap(trap(amo_insn(AMO_OPS[k], tied_pkg::F3_WORD, 5'd10, 5'd11, 5'd12,
				2'b00), 1'b1, wold, wsrc));
		// doubleword carry out and signed compare
		send_trap(trap(amo_insn(tied_pkg::AMO_ADD, tied_pkg::F3_DOUBLE, 5'd31, 5'd31, 5'd31,
			2'b11), 1'b0, '1, 64'd1));
		send_trap(trap(amo_insn(tied_pkg::AMO_MIN, tied_pkg::F3_DOUBLE, 5'd1, 5'd2, 5'd3,
			2'b01), 1'b0, 64'h8000_0000_0000_0000, 64'd1));
		// lr, sc and a byte-width amo are not emulated
		send_trap(trap(amo_insn(F5_LR, tied_pkg::F3_WORD, 5'd1, 5'd2, 5'd0, 2'b10), 1'b0,
			wold, wsrc));
		send_trap(trap(amo_insn(F5_SC, tied_pkg::F3_DOUBLE, 5'd1, 5'd2, 5'd3, 2'b00), 1'b0,
			wold, wsrc));
		send_trap(trap(amo_insn(tied_pkg::AMO_SWAP, F3_BYTE, 5'd1, 5'd2, 5'd3, 2'b00), 1'b0,
			wold, wsrc));
		drain();
		// everything enabled: user reads go through, high halves still refused
		set_counters('1, '1);
		send_trap(trap(csr_insn(CSR_LO + 12'd1, F3_CSRRS, 5'd8, 5'd0), 1'b1, '0, '0));
		send_trap(trap(csr_insn(CSR_LO + 12'd31, F3_CSRRCI, 5'd9, 5'd0), 1'b1, '0, '0));
		send_trap(trap(csr_insn(CSR_HI + 12'd31, F3_CSRRS, 5'd9, 5'd0), 1'b1, '0, '0));
		drain();
	endtask

	// stimulus and end of run
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: set_counters('1, '1);
				1: set_counters('0, '0);
				2: set_counters($urandom, $urandom);
				3: set_counters('0, tied_pkg::COUNTER_PRESENT_RST);
				4: set_counters($urandom, '1);
				default: set_counters('1, $urandom);
			endcase
			// idle profile: slow receiver, then slow sender, then full rate
			if (ph < 2) begin
				send_idle_pct = 35;
				take_idle_pct <= 80;
			end else if (ph < 4) begin
				send_idle_pct = 80;
				take_idle_pct <= 35;
			end else begin
				send_idle_pct = 0;
				take_idle_pct <= 0;
			end
			// long receiver stall while items keep coming, so full must rise
			if (ph == 4) begin
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			repeat (PHASE_ITEMS) send_trap(random_trap());
			drain();
		end
		$display("checked %0d trapped items over %0d counter register settings",
			decodes.checked, settings);
		$display("%0d redirects, %0d counter reads, %0d amos", decodes.redirects,
			decodes.counter_reads, decodes.amos);
		if (decodes.mismatches == 0 && decodes.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
